/* rtl/core/ndd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the nearest-neighbor downscaler.
// No dependencies; all files but ndd_chan_if refer to it by scoped names.
package ndd_pkg;

    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int PIX_W       = 16;
    localparam int DCOORD_W    = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_H = 2'd3;

    localparam logic [CFG_W-1:0] RST_SRC_W = 12'd320;
    localparam logic [CFG_W-1:0] RST_SRC_H = 12'd240;
    localparam logic [CFG_W-1:0] RST_DST_W = 12'd160;
    localparam logic [CFG_W-1:0] RST_DST_H = 12'd120;

    typedef struct packed {
        logic [CFG_W-1:0] src_w;
        logic [CFG_W-1:0] src_h;
        logic [CFG_W-1:0] dst_w;
        logic [CFG_W-1:0] dst_h;
    } t_cfg;

    typedef struct packed {
        logic             busy;
        logic [CFG_W-1:0] q_col;
        logic [CFG_W-1:0] r_col;
        logic [CFG_W-1:0] q_row;
        logic [CFG_W-1:0] r_row;
    } t_setup;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel_out;
        logic [DCOORD_W-1:0] dest_col;
        logic [DCOORD_W-1:0] dest_row;
        logic                frame_last;
        logic                config_error;
    } t_out_word;

endpackage

/* rtl/core/ndd_chan_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one word of type T.
// Depends on nothing; the payload type comes from the instance.
interface ndd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ndd_div.sv */
`timescale 1ns / 1ps
// Setup divider: (src-1)/(dst-1) quotient and remainder for columns, then rows.
// One restoring step per cycle on a shared unit. Depends on ndd_pkg.
module ndd_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ndd_pkg::t_cfg   i_cfg,
    output ndd_pkg::t_setup o_setup
);
    localparam int W    = ndd_pkg::CFG_W;
    localparam int CNTW = $clog2(W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_COL  = 2'd2;
    localparam logic [1:0] ST_ROW  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [W-1:0]    r_quo, n_quo;
    logic [W-1:0]    r_rem, n_rem;
    logic [W-1:0]    r_den, n_den;
    logic [W-1:0]    r_q_col, n_q_col, r_r_col, n_r_col;
    logic [W-1:0]    r_q_row, n_q_row, r_r_row, n_r_row;

    logic [W:0]   shifted;
    logic         ge;
    logic [W-1:0] rem_step;
    logic [W-1:0] quo_step;
    logic         last_step;

    always_comb begin
        shifted   = {r_rem, r_quo[W-1]};
        ge        = shifted >= {1'b0, r_den};
        rem_step  = ge ? W'(shifted - {1'b0, r_den}) : W'(shifted);
        quo_step  = {r_quo[W-2:0], ge};
        last_step = r_cnt == CNTW'(W - 1);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 1'b1;
        n_quo   = quo_step;
        n_rem   = rem_step;
        n_den   = r_den;
        n_q_col = r_q_col;
        n_r_col = r_r_col;
        n_q_row = r_q_row;
        n_r_row = r_r_row;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = r_cnt;
                n_quo = r_quo;
                n_rem = r_rem;
            end
            ST_LOAD: begin
                n_cnt   = '0;
                n_quo   = i_cfg.src_w - 1'b1;
                n_den   = i_cfg.dst_w - 1'b1;
                n_rem   = '0;
                n_state = ST_COL;
            end
            ST_COL: begin
                if (last_step) begin
                    n_q_col = quo_step;
                    n_r_col = rem_step;
                    n_cnt   = '0;
                    n_quo   = i_cfg.src_h - 1'b1;
                    n_den   = i_cfg.dst_h - 1'b1;
                    n_rem   = '0;
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                if (last_step) begin
                    n_q_row = quo_step;
                    n_r_row = rem_step;
                    n_state = ST_IDLE;
                end
            end
        endcase
        if (i_start) begin
            n_state = ST_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_q_col <= n_q_col;
        r_r_col <= n_r_col;
        r_q_row <= n_q_row;
        r_r_row <= n_r_row;
    end

    assign o_setup.busy  = r_state != ST_IDLE;
    assign o_setup.q_col = r_q_col;
    assign o_setup.r_col = r_r_col;
    assign o_setup.q_row = r_q_row;
    assign o_setup.r_row = r_r_row;

`ifndef SYNTHESIS
    a_busy_ends_after_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_setup.busy) |-> $past(r_state) == ST_ROW)
        else $error("setup finished outside the row phase");
`endif

endmodule

/* rtl/core/ndd_front.sv */
`timescale 1ns / 1ps
// Front end: accept source pixels, track source and destination positions,
// select pixels and emit result words. Depends on ndd_pkg and ndd_chan_if.
module ndd_front #(
    parameter int CW = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ndd_pkg::t_cfg      i_cfg,
    input  logic               i_cfg_ok,
    input  ndd_pkg::t_setup    i_setup,
    input  logic               i_full,
    ndd_chan_if.sink           i_pix,
    output logic               o_push,
    output ndd_pkg::t_out_word o_word
);
    localparam int W = ndd_pkg::CFG_W;

    logic [CW-1:0] r_scol, n_scol, r_srow, n_srow;
    logic [CW-1:0] r_dcol, n_dcol, r_drow, n_drow;
    logic [CW-1:0] r_tcol, n_tcol, r_trow, n_trow;
    logic [W-1:0]  r_acol, n_acol, r_arow, n_arow;

    logic [CW-1:0] init_col, init_row;
    logic [CW-1:0] c_scol, c_srow, c_dcol, c_drow, c_tcol, c_trow;
    logic [W-1:0]  c_acol, c_arow;
    logic          accept, fs, hit, col_more, row_more, last, row_end, frame_end;
    logic [W:0]    sum_col, sum_row, dw_m1, dh_m1;
    logic          wrap_col, wrap_row;

    assign i_pix.ready = !i_setup.busy && !i_full;
    assign accept      = i_pix.valid && i_pix.ready;
    assign fs          = i_pix.data.frame_start;

    always_comb begin
        init_col = (i_cfg.dst_w <= W'(1)) ? CW'(i_cfg.src_w >> 1) : '0;
        init_row = (i_cfg.dst_h <= W'(1)) ? CW'(i_cfg.src_h >> 1) : '0;
        c_scol   = fs ? '0 : r_scol;
        c_srow   = fs ? '0 : r_srow;
        c_dcol   = fs ? '0 : r_dcol;
        c_drow   = fs ? '0 : r_drow;
        c_tcol   = fs ? init_col : r_tcol;
        c_trow   = fs ? init_row : r_trow;
        c_acol   = fs ? '0 : r_acol;
        c_arow   = fs ? '0 : r_arow;

        hit       = c_srow == c_trow && c_scol == c_tcol;
        col_more  = (W + 1)'(c_dcol) + 1'b1 < {1'b0, i_cfg.dst_w};
        row_more  = (W + 1)'(c_drow) + 1'b1 < {1'b0, i_cfg.dst_h};
        last      = !col_more && !row_more;
        row_end   = (W + 1)'(c_scol) + 1'b1 >= {1'b0, i_cfg.src_w};
        frame_end = (W + 1)'(c_srow) + 1'b1 >= {1'b0, i_cfg.src_h};

        dw_m1    = {1'b0, i_cfg.dst_w} - 1'b1;
        dh_m1    = {1'b0, i_cfg.dst_h} - 1'b1;
        sum_col  = {1'b0, c_acol} + {1'b0, i_setup.r_col};
        sum_row  = {1'b0, c_arow} + {1'b0, i_setup.r_row};
        wrap_col = sum_col >= dw_m1;
        wrap_row = sum_row >= dh_m1;
    end

    always_comb begin
        n_scol = r_scol;
        n_srow = r_srow;
        n_dcol = r_dcol;
        n_drow = r_drow;
        n_tcol = r_tcol;
        n_trow = r_trow;
        n_acol = r_acol;
        n_arow = r_arow;
        if (accept && i_cfg_ok) begin
            n_scol = c_scol + 1'b1;
            n_srow = c_srow;
            n_dcol = c_dcol;
            n_drow = c_drow;
            n_tcol = c_tcol;
            n_trow = c_trow;
            n_acol = c_acol;
            n_arow = c_arow;
            if (hit && col_more) begin
                n_dcol = c_dcol + 1'b1;
                n_tcol = CW'((W + 1)'(c_tcol) + (W + 1)'(i_setup.q_col)
                             + (W + 1)'(wrap_col));
                n_acol = wrap_col ? W'(sum_col - dw_m1) : W'(sum_col);
            end
            if (row_end) begin
                n_scol = '0;
                n_srow = c_srow + 1'b1;
                if (c_srow == c_trow && row_more) begin
                    n_drow = c_drow + 1'b1;
                    n_trow = CW'((W + 1)'(c_trow) + (W + 1)'(i_setup.q_row)
                                 + (W + 1)'(wrap_row));
                    n_arow = wrap_row ? W'(sum_row - dh_m1) : W'(sum_row);
                    n_dcol = '0;
                    n_tcol = init_col;
                    n_acol = '0;
                end
            end
        end
        if (i_setup.busy || (accept && (!i_cfg_ok || (row_end && frame_end)))) begin
            n_scol = '0;
            n_srow = '0;
            n_dcol = '0;
            n_drow = '0;
            n_tcol = init_col;
            n_trow = init_row;
            n_acol = '0;
            n_arow = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol <= '0;
            r_srow <= '0;
            r_dcol <= '0;
            r_drow <= '0;
            r_tcol <= '0;
            r_trow <= '0;
            r_acol <= '0;
            r_arow <= '0;
        end else begin
            r_scol <= n_scol;
            r_srow <= n_srow;
            r_dcol <= n_dcol;
            r_drow <= n_drow;
            r_tcol <= n_tcol;
            r_trow <= n_trow;
            r_acol <= n_acol;
            r_arow <= n_arow;
        end
    end

    always_comb begin
        o_push = accept && (!i_cfg_ok || hit);
        o_word = '0;
        if (!i_cfg_ok) begin
            o_word.config_error = 1'b1;
        end else begin
            o_word.pixel_out  = i_pix.data.pixel_in;
            o_word.dest_col   = ndd_pkg::DCOORD_W'(c_dcol);
            o_word.dest_row   = ndd_pkg::DCOORD_W'(c_drow);
            o_word.frame_last = last;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_setup.busy) |-> r_scol == '0 && r_srow == '0 && r_dcol == '0)
        else $error("position moved during setup");
    a_error_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_word.config_error |-> o_word.pixel_out == '0 && !o_word.frame_last)
        else $error("error word carries pixel data");
`endif

endmodule

/* rtl/core/ndd_queue.sv */
`timescale 1ns / 1ps
// Back end: short result queue that drives the output channel and decouples
// the receiver from the front end. Depends on ndd_pkg and ndd_chan_if.
module ndd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ndd_pkg::t_out_word i_word,
    output logic               o_full,
    ndd_chan_if.source         o_pix
);
    localparam int DEPTH = ndd_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    ndd_pkg::t_out_word r_mem [DEPTH];
    logic [PW-1:0]      r_wr, r_rd;
    logic [PW:0]        r_count, n_count;
    logic               pop;

    assign pop         = o_pix.valid && o_pix.ready;
    assign o_full      = r_count == (PW + 1)'(DEPTH);
    assign o_pix.valid = r_count != '0;
    assign o_pix.data  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("word pushed into full queue");
    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == (PW + 1)'(1) && pop && !i_push |=> !o_pix.valid)
        else $error("queue shows a word after draining");
`endif

endmodule

/* rtl/core/nearest_neighbor_downscaler_top.sv */
`timescale 1ns / 1ps
// Nearest-neighbor downscaler for RGB565 pixel streams.
// i_pix takes source pixels in raster order; frame_start on a word restarts
// the frame position. o_pix gives the selected pixels in destination raster
// order with their destination column and row, frame_last on the last one,
// and config_error words (one per input word) while the sizes are invalid.
// Registers: index 0 source width, 1 source height, 2 destination width,
// 3 destination height, written through i_cfg_we / i_cfg_idx / i_cfg_data.
// After reset and after every register write a shared divider computes the
// column and row step ratios while i_pix.ready is held low.
// Then one pixel is accepted per cycle unless the queue is full. Each selected
// pixel goes into a registered four-word result queue that drives o_pix and
// absorbs receiver stalls; once full, i_pix.ready drops until a word is taken.
// Reset restores sizes 320x240 to 160x120 and clears the frame position.
module nearest_neighbor_downscaler_top #(
    parameter int MAX_DIMENSION = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ndd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ndd_pkg::CFG_W-1:0]     i_cfg_data,
    ndd_chan_if.sink                      i_pix,
    ndd_chan_if.source                    o_pix
);
    localparam int W  = ndd_pkg::CFG_W;
    localparam int CW = $clog2(MAX_DIMENSION);
    localparam logic [W:0] MAX_V = (W + 1)'(MAX_DIMENSION);

    ndd_pkg::t_cfg      r_cfg;
    logic               r_cfg_ok, n_cfg_ok;
    ndd_pkg::t_setup    setup;
    ndd_pkg::t_out_word word;
    logic               push;
    logic               full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w <= ndd_pkg::RST_SRC_W;
            r_cfg.src_h <= ndd_pkg::RST_SRC_H;
            r_cfg.dst_w <= ndd_pkg::RST_DST_W;
            r_cfg.dst_h <= ndd_pkg::RST_DST_H;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ndd_pkg::REG_SRC_W: r_cfg.src_w <= i_cfg_data;
                ndd_pkg::REG_SRC_H: r_cfg.src_h <= i_cfg_data;
                ndd_pkg::REG_DST_W: r_cfg.dst_w <= i_cfg_data;
                ndd_pkg::REG_DST_H: r_cfg.dst_h <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_cfg_ok = r_cfg.src_w != '0 && {1'b0, r_cfg.src_w} <= MAX_V
                && r_cfg.src_h != '0 && {1'b0, r_cfg.src_h} <= MAX_V
                && r_cfg.dst_w != '0 && {1'b0, r_cfg.dst_w} <= MAX_V
                && r_cfg.dst_h != '0 && {1'b0, r_cfg.dst_h} <= MAX_V
                && r_cfg.dst_w <= r_cfg.src_w && r_cfg.dst_h <= r_cfg.src_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ok <= 1'b0;
        end else begin
            r_cfg_ok <= n_cfg_ok;
        end
    end

    ndd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_cfg   (r_cfg),
        .o_setup (setup)
    );

    ndd_front #(
        .CW (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_ok (r_cfg_ok),
        .i_setup  (setup),
        .i_full   (full),
        .i_pix    (i_pix),
        .o_push   (push),
        .o_word   (word)
    );

    ndd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (word),
        .o_full  (full),
        .o_pix   (o_pix)
    );

endmodule

/* test/nearest_neighbor_downscaler_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for nearest_neighbor_downscaler_top: a directed table, then random frames.
// Depends on ndd_pkg, ndd_chan_if and the block; a scaler model or table gives expected words.
module nearest_neighbor_downscaler_top_test;

    localparam int CFG_W         = ndd_pkg::CFG_W;
    localparam int CFG_IDX_W     = ndd_pkg::CFG_IDX_W;
    localparam int PIX_W         = ndd_pkg::PIX_W;
    localparam int DCOORD_W      = ndd_pkg::DCOORD_W;
    localparam int MAX_DIM       = 2048;
    localparam int RANDOM_WORDS  = 1050;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    localparam ndd_pkg::t_out_word SIZE_ERROR_WORD = '{pixel_out: '0, dest_col: '0,
                                                       dest_row: '0, frame_last: 1'b0,
                                                       config_error: 1'b1};

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        ndd_pkg::t_in_word    word;
        bit                   typed;
        ndd_pkg::t_out_word   want;
    } t_step_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ndd_chan_if #(.T(ndd_pkg::t_in_word))  pix_in_ch ();
    ndd_chan_if #(.T(ndd_pkg::t_out_word)) pix_out_ch ();

    nearest_neighbor_downscaler_top #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix     (pix_in_ch),
        .o_pix     (pix_out_ch)
    );

    // scaler model: sizes and frame position
    logic [CFG_W-1:0] src_w, src_h, dst_w, dst_h;
    logic [CFG_W-1:0] col_pos, row_pos, tgt_col, tgt_row, out_col, out_row;

    ndd_pkg::t_out_word scaled_q[$];
    t_step_row          plan[$];

    bit                 in_typed = 1'b0;
    ndd_pkg::t_out_word in_typed_word = '0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 cycle_count = 0;
    int                 errors = 0;
    int                 words_in = 0;
    int                 results_seen = 0;
    int                 size_settings = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    always @(posedge i_clk) pix_out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic void expect_word(input ndd_pkg::t_out_word w);
        scaled_q.insert(scaled_q.size(), w);
    endfunction

    function automatic void plan_row(input t_step_row r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic logic [CFG_W-1:0] source_index(int unsigned idx, int unsigned s,
                                                      int unsigned d);
        if (d <= 1) begin
            return CFG_W'(s / 2);
        end
        return CFG_W'((idx * (s - 1)) / (d - 1));
    endfunction

    function automatic bit sizes_ok();
        if (src_w < 1 || src_w > MAX_DIM || src_h < 1 || src_h > MAX_DIM) return 1'b0;
        if (dst_w < 1 || dst_w > MAX_DIM || dst_h < 1 || dst_h > MAX_DIM) return 1'b0;
        return (dst_w <= src_w) && (dst_h <= src_h);
    endfunction

    task automatic restart_frame();
        col_pos = '0;
        row_pos = '0;
        out_col = '0;
        out_row = '0;
        if (sizes_ok()) begin
            tgt_col = source_index(0, src_w, dst_w);
            tgt_row = source_index(0, src_h, dst_h);
        end else begin
            tgt_col = '0;
            tgt_row = '0;
        end
    endtask

    task automatic step_scaler(input ndd_pkg::t_in_word w, output bit produced,
                               output ndd_pkg::t_out_word r);
        produced = 1'b0;
        r = '0;
        if (!sizes_ok()) begin
            restart_frame();
            r = SIZE_ERROR_WORD;
            produced = 1'b1;
        end else begin
            if (w.frame_start) restart_frame();
            if (row_pos == tgt_row && col_pos == tgt_col) begin
                r.pixel_out  = w.pixel_in;
                r.dest_col   = out_col[DCOORD_W-1:0];
                r.dest_row   = out_row[DCOORD_W-1:0];
                r.frame_last = (out_col + 12'd1 >= dst_w) && (out_row + 12'd1 >= dst_h);
                produced = 1'b1;
                if (out_col + 12'd1 < dst_w) begin
                    out_col = out_col + 12'd1;
                    tgt_col = source_index(out_col, src_w, dst_w);
                end
            end
            col_pos = col_pos + 12'd1;
            if (col_pos >= src_w) begin
                col_pos = '0;
                if (row_pos == tgt_row && out_row + 12'd1 < dst_h) begin
                    out_row = out_row + 12'd1;
                    tgt_row = source_index(out_row, src_h, dst_h);
                    out_col = '0;
                    tgt_col = source_index(0, src_w, dst_w);
                end
                row_pos = row_pos + 12'd1;
                if (row_pos >= src_h) restart_frame();
            end
        end
    endtask

    always @(posedge i_clk) begin
        bit                 produced;
        ndd_pkg::t_out_word predicted;
        ndd_pkg::t_out_word got;
        ndd_pkg::t_out_word want;
        if (i_rst_n === 1'b1) begin
            if (pix_in_ch.valid === 1'b1 && pix_in_ch.ready === 1'b1) begin
                step_scaler(pix_in_ch.data, produced, predicted);
                words_in++;
                if (in_typed) expect_word(in_typed_word);
                else if (produced) expect_word(predicted);
            end
            if (pix_out_ch.valid === 1'b1 && pix_out_ch.ready === 1'b1) begin
                got = pix_out_ch.data;
                results_seen++;
                if (scaled_q.size() == 0) begin
                    $error("unexpected output word %h", got);
                    errors++;
                end else begin
                    want = scaled_q.pop_front();
                    if (got.pixel_out !== want.pixel_out) begin
                        $error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
                        errors++;
                    end
                    if (got.dest_col !== want.dest_col) begin
                        $error("dest_col: expected %0d, got %0d", want.dest_col, got.dest_col);
                        errors++;
                    end
                    if (got.dest_row !== want.dest_row) begin
                        $error("dest_row: expected %0d, got %0d", want.dest_row, got.dest_row);
                        errors++;
                    end
                    if (got.frame_last !== want.frame_last) begin
                        $error("frame_last: expected %b, got %b", want.frame_last,
                               got.frame_last);
                        errors++;
                    end
                    if (got.config_error !== want.config_error) begin
                        $error("config_error: expected %b, got %b", want.config_error,
                               got.config_error);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            ndd_pkg::REG_SRC_W: src_w = CFG_W'(val);
            ndd_pkg::REG_SRC_H: src_h = CFG_W'(val);
            ndd_pkg::REG_DST_W: dst_w = CFG_W'(val);
            ndd_pkg::REG_DST_H: dst_h = CFG_W'(val);
        endcase
        restart_frame();
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit fs, input bit typed,
                              input ndd_pkg::t_out_word want);
        int                gap;
        ndd_pkg::t_in_word w;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            pix_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.pixel_in    = pix;
        w.frame_start = fs;
        pix_in_ch.valid <= 1'b1;
        pix_in_ch.data  <= w;
        in_typed        <= typed;
        in_typed_word   <= want;
        do @(posedge i_clk); while (pix_in_ch.ready !== 1'b1);
    endtask

    // hold the sender until every output word is in, then let the pipeline empty
    task automatic settle();
        pix_in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (scaled_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        t_step_row r;
        r = '{kind: ROW_CFG, reg_idx: idx, reg_val: CFG_W'(val), word: '0, typed: 1'b0,
              want: '0};
        plan_row(r);
    endtask

    task automatic add_pix(input logic [PIX_W-1:0] pix, input bit fs, input bit typed,
                           input ndd_pkg::t_out_word want);
        t_step_row r;
        r = '{kind: ROW_PIX, reg_idx: '0, reg_val: '0, word: '{pixel_in: pix, frame_start: fs},
              typed: typed, want: want};
        plan_row(r);
    endtask

    function automatic ndd_pkg::t_out_word scaled_word(logic [PIX_W-1:0] pix, int unsigned col,
                                                       int unsigned row, bit last);
        return '{pixel_out: pix, dest_col: DCOORD_W'(col), dest_row: DCOORD_W'(row),
                 frame_last: last, config_error: 1'b0};
    endfunction

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned sw, sh, dw, dh;
        int unsigned frame_len, len, pick;
        int          phase_no, phase_left, random_words, k;
        bit          noisy, fs;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        pix_in_ch.valid  = 1'b0;
        pix_in_ch.data   = '0;
        pix_out_ch.ready = 1'b0;
        src_w = ndd_pkg::RST_SRC_W;
        src_h = ndd_pkg::RST_SRC_H;
        dst_w = ndd_pkg::RST_DST_W;
        dst_h = ndd_pkg::RST_DST_H;
        restart_frame();

        // reset sizes, then the smallest frame, invalid sizes and the widest row
        add_pix(16'hFFFF, 1'b1, 1'b1, scaled_word(16'hFFFF, 0, 0, 1'b0));
        add_pix(16'h0000, 1'b0, 1'b0, '0);
        add_pix(16'hA5A5, 1'b0, 1'b0, '0);
        add_cfg(ndd_pkg::REG_SRC_W, 1);
        add_cfg(ndd_pkg::REG_SRC_H, 1);
        add_cfg(ndd_pkg::REG_DST_W, 1);
        add_cfg(ndd_pkg::REG_DST_H, 1);
        add_pix(16'hFFFF, 1'b1, 1'b1, scaled_word(16'hFFFF, 0, 0, 1'b1));
        add_pix(16'h0000, 1'b0, 1'b1, scaled_word(16'h0000, 0, 0, 1'b1));
        add_cfg(ndd_pkg::REG_DST_W, 2);
        add_pix(16'hFFFF, 1'b1, 1'b1, SIZE_ERROR_WORD);
        add_pix(16'h1234, 1'b0, 1'b1, SIZE_ERROR_WORD);
        add_cfg(ndd_pkg::REG_DST_W, 0);
        add_pix(16'h0000, 1'b1, 1'b1, SIZE_ERROR_WORD);
        add_cfg(ndd_pkg::REG_DST_W, 1);
        add_cfg(ndd_pkg::REG_SRC_W, 4095);
        add_pix(16'hFFFF, 1'b0, 1'b1, SIZE_ERROR_WORD);
        add_cfg(ndd_pkg::REG_SRC_W, 2048);
        add_cfg(ndd_pkg::REG_DST_W, 2048);
        add_pix(16'h8000, 1'b1, 1'b1, scaled_word(16'h8000, 0, 0, 1'b0));
        add_pix(16'h0001, 1'b0, 1'b0, '0);
        add_pix(16'h7FFF, 1'b0, 1'b0, '0);
        // 3x2 down to 1x1: one pick mid-frame, then overrun and a restart
        add_cfg(ndd_pkg::REG_SRC_W, 3);
        add_cfg(ndd_pkg::REG_SRC_H, 2);
        add_cfg(ndd_pkg::REG_DST_W, 1);
        add_cfg(ndd_pkg::REG_DST_H, 1);
        for (k = 0; k < 13; k++) begin
            add_pix(PIX_W'(16'h1111 * (k + 1)), (k == 0 || k == 8), 1'b0, '0);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        size_settings = 1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                if (i == 0 || plan[i - 1].kind != ROW_CFG) begin
                    settle();
                    size_settings++;
                end
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_pixel(plan[i].word.pixel_in, plan[i].word.frame_start, plan[i].typed,
                           plan[i].want);
            end
        end

        phase_no = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            settle();
            pick = $urandom_range(99);
            if (phase_no == 0) begin
                sw = MAX_DIM; sh = MAX_DIM; dw = MAX_DIM; dh = MAX_DIM;
            end else if (phase_no == 1) begin
                sw = 4095; sh = 4095; dw = 4095; dh = 4095;
            end else if (pick < 75) begin
                sw = $urandom_range(12, 1);
                sh = $urandom_range(8, 1);
                dw = $urandom_range(sw, 1);
                dh = $urandom_range(sh, 1);
                if (pick >= 60 && pick < 66) dw = sw + $urandom_range(4, 1);
                else if (pick >= 66 && pick < 70) dh = sh + 1;
                else if (pick >= 70) begin
                    case ($urandom_range(3))
                        0: sw = 0;
                        1: sh = 0;
                        2: dw = 0;
                        default: dh = 0;
                    endcase
                end
            end else if (pick < 80) begin
                sw = $urandom_range(12, 1);
                sh = $urandom_range(8, 1);
                dw = 1;
                dh = 1;
                case ($urandom_range(3))
                    0: sw = $urandom_range(4095, MAX_DIM + 1);
                    1: sh = $urandom_range(4095, MAX_DIM + 1);
                    2: dw = $urandom_range(4095, MAX_DIM + 1);
                    default: dh = $urandom_range(4095, MAX_DIM + 1);
                endcase
            end else if (pick < 90) begin
                sw = MAX_DIM;
                sh = $urandom_range(2, 1);
                case ($urandom_range(3))
                    0: dw = 1;
                    1: dw = 2;
                    2: dw = MAX_DIM;
                    default: dw = $urandom_range(MAX_DIM, 1);
                endcase
                dh = $urandom_range(sh, 1);
            end else begin
                sw = $urandom_range(4, 1);
                sh = MAX_DIM;
                dw = $urandom_range(sw, 1);
                case ($urandom_range(2))
                    0: dh = 1;
                    1: dh = MAX_DIM;
                    default: dh = $urandom_range(MAX_DIM, 1);
                endcase
            end
            write_reg(ndd_pkg::REG_SRC_W, sw);
            write_reg(ndd_pkg::REG_SRC_H, sh);
            write_reg(ndd_pkg::REG_DST_W, dw);
            write_reg(ndd_pkg::REG_DST_H, dh);
            size_settings++;

            case (phase_no % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase

            frame_len = sw * sh;
            if (frame_len == 0) frame_len = 1;
            phase_left = $urandom_range(80, 40);
            while (phase_left > 0) begin
                pick = $urandom_range(99);
                noisy = 1'b0;
                if (pick < 80) len = frame_len;
                else if (pick < 90) len = $urandom_range(frame_len, 1);
                else begin
                    len = $urandom_range(20, 1);
                    noisy = 1'b1;
                end
                for (k = 0; k < len && phase_left > 0; k++) begin
                    fs = noisy ? ($urandom_range(7) == 0) : (k == 0);
                    send_pixel(PIX_W'($urandom_range(16'hFFFF)), fs, 1'b0, '0);
                    phase_left--;
                    random_words++;
                end
                if ($urandom_range(99) < 5) settle();
            end
            phase_no++;
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        settle();
        $display("Fed %0d source words over %0d size settings; %0d output words checked.",
                 words_in, size_settings, results_seen);
        $display("Mismatches and stray words: %0d", errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/core/ndd_pkg.sv
rtl/core/ndd_chan_if.sv
rtl/core/ndd_div.sv
rtl/core/ndd_front.sv
rtl/core/ndd_queue.sv
rtl/core/nearest_neighbor_downscaler_top.sv
test/nearest_neighbor_downscaler_top_test.sv
